/* rtl/core/command_selected_waveform_generator_defines.svh */
// ----------------------------------------------------------------------------
// Waveform generator assertion macros
// Clocked property wrappers used by the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef COMMAND_SELECTED_WAVEFORM_GENERATOR_DEFINES_SVH
`define COMMAND_SELECTED_WAVEFORM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CWG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwg assertion failed");

// next-cycle implication
`define CWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwg assertion failed");

`else

`define CWG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CWG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/cwg_pkg.sv */
// ----------------------------------------------------------------------------
// Waveform generator package
// Widths, mode and announce codes, command characters and the sine table.
// ----------------------------------------------------------------------------
package cwg_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int LEVEL_W     = 8;
    localparam int INDEX_W     = $clog2(2 * TABLE_DEPTH);
    localparam int DELAY_W     = 16;
    localparam int ANN_W       = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [INDEX_W-1:0] LEN_SHORT = INDEX_W'(TABLE_DEPTH);
    localparam logic [INDEX_W-1:0] LEN_LONG  = INDEX_W'(2 * TABLE_DEPTH - 1);

    localparam logic [DELAY_W-1:0] SLOW_DELAY_RST = 16'd5150;
    localparam logic [DELAY_W-1:0] FAST_DELAY_RST = 16'd2550;

    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY = 1'b1;

    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_TRI    = 2'd1;
    localparam logic [1:0] MODE_SQUARE = 2'd2;
    localparam logic [1:0] MODE_SAW    = 2'd3;

    localparam logic [ANN_W-1:0] ANN_NONE   = 3'd0;
    localparam logic [ANN_W-1:0] ANN_SINE   = 3'd1;
    localparam logic [ANN_W-1:0] ANN_TRI    = 3'd2;
    localparam logic [ANN_W-1:0] ANN_SQUARE = 3'd3;
    localparam logic [ANN_W-1:0] ANN_SAW    = 3'd4;

    localparam logic [7:0] CHAR_SINE   = 8'h73; // 's'
    localparam logic [7:0] CHAR_TRI    = 8'h74; // 't'
    localparam logic [7:0] CHAR_SQUARE = 8'h71; // 'q'
    localparam logic [7:0] CHAR_SAW    = 8'h72; // 'r'

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 8'hFF;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'h00;

    typedef struct packed {
        logic         kind;
        logic [7:0]   rx_byte;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] dac_level;
        logic               sample_strobe;
        logic [ANN_W-1:0]   announce;
    } result_t;

    typedef struct packed {
        logic [INDEX_W-1:0] sample_index;
        logic [DELAY_W-1:0] hold_count;
    } core_stat_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } buf_stat_t;

    localparam logic [LEVEL_W-1:0] SINE_ROM [TABLE_DEPTH] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
        8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd235, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd244,
        8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252,
        8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd212, 8'd210, 8'd207, 8'd205, 8'd202, 8'd200,
        8'd197, 8'd195, 8'd192, 8'd189, 8'd186, 8'd184, 8'd181, 8'd178,
        8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
        8'd151, 8'd148, 8'd145, 8'd142, 8'd138, 8'd135, 8'd132, 8'd129,
        8'd126, 8'd123, 8'd120, 8'd117, 8'd113, 8'd110, 8'd107, 8'd104,
        8'd101, 8'd98,  8'd95,  8'd92,  8'd89,  8'd86,  8'd83,  8'd80,
        8'd77,  8'd74,  8'd71,  8'd69,  8'd66,  8'd63,  8'd60,  8'd58,
        8'd55,  8'd53,  8'd50,  8'd48,  8'd45,  8'd43,  8'd40,  8'd38,
        8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd26,  8'd24,  8'd22,
        8'd20,  8'd19,  8'd17,  8'd16,  8'd14,  8'd13,  8'd11,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
        8'd3,   8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
        8'd11,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd20,  8'd21,
        8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,  8'd37,
        8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,  8'd56,
        8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,  8'd79,
        8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,  8'd103,
        8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124, 8'd128
    };

    function automatic logic [INDEX_W-1:0] period_len(input logic [1:0] mode);
        logic [INDEX_W-1:0] len;
        if (mode == MODE_TRI || mode == MODE_SQUARE)
        begin
            len = LEN_LONG;
        end
        else
        begin
            len = LEN_SHORT;
        end
        return len;
    endfunction

    function automatic logic [LEVEL_W-1:0] sample_level(
        input logic [1:0]         mode,
        input logic [INDEX_W-1:0] idx
    );
        logic               first_half;
        logic [INDEX_W-1:0] down;
        logic [LEVEL_W-1:0] lvl;
        first_half = (idx < LEN_SHORT);
        down       = LEN_LONG - idx;
        case (mode)
            MODE_SINE:   lvl = SINE_ROM[idx[LEVEL_W-1:0]];
            MODE_TRI:    lvl = first_half ? idx[LEVEL_W-1:0] : down[LEVEL_W-1:0];
            MODE_SQUARE: lvl = first_half ? LEVEL_HIGH : LEVEL_LOW;
            default:     lvl = idx[LEVEL_W-1:0];
        endcase
        return lvl;
    endfunction

endpackage

/* rtl/core/cwg_if.sv */
// ----------------------------------------------------------------------------
// Waveform generator channel interfaces
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface cwg_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface cwg_out_if;
    logic                          valid;
    logic                          ready;
    logic [cwg_pkg::LEVEL_W-1:0]   dac_level;
    logic                          sample_strobe;
    logic [cwg_pkg::ANN_W-1:0]     announce;

    modport source (output valid, output dac_level, output sample_strobe,
                    output announce, input ready);
    modport sink   (input valid, input dac_level, input sample_strobe,
                    input announce, output ready);
endinterface

/* rtl/core/cwg_wave_core.sv */
// ----------------------------------------------------------------------------
// Waveform generator state core
// Delay registers, mode, sample index and hold counter; one beat per cycle while accept is high.
// ----------------------------------------------------------------------------
module cwg_wave_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cwg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwg_pkg::DELAY_W-1:0]      cfg_data,
    input  logic                             accept,
    input  cwg_pkg::item_t                   item,
    output cwg_pkg::result_t                 result,
    output cwg_pkg::core_stat_t              stat
);

    logic [cwg_pkg::DELAY_W-1:0] slow_delay_reg;
    logic [cwg_pkg::DELAY_W-1:0] fast_delay_reg;
    logic [1:0]                  wave_mode_reg;
    logic [1:0]                  wave_mode_next;
    logic [1:0]                  pending_mode_reg;
    logic [1:0]                  pending_mode_next;
    logic [cwg_pkg::INDEX_W-1:0] sample_index_reg;
    logic [cwg_pkg::INDEX_W-1:0] sample_index_next;
    logic [cwg_pkg::DELAY_W-1:0] hold_count_reg;
    logic [cwg_pkg::DELAY_W-1:0] hold_count_next;
    logic [cwg_pkg::LEVEL_W-1:0] level_reg;
    logic [cwg_pkg::LEVEL_W-1:0] level_next;

    logic [1:0]                  mode_eff;
    logic [cwg_pkg::INDEX_W-1:0] len;
    logic [cwg_pkg::INDEX_W-1:0] idx_eff;
    logic [cwg_pkg::INDEX_W-1:0] idx_inc;
    logic [cwg_pkg::DELAY_W-1:0] delay_sel;
    logic [cwg_pkg::ANN_W-1:0]   announce;
    logic                        strobe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_delay_reg <= cwg_pkg::SLOW_DELAY_RST;
            fast_delay_reg <= cwg_pkg::FAST_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cwg_pkg::REG_SLOW_DELAY: slow_delay_reg <= cfg_data;
                cwg_pkg::REG_FAST_DELAY: fast_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mode_eff  = (sample_index_reg == '0) ? pending_mode_reg : wave_mode_reg;
        len       = cwg_pkg::period_len(mode_eff);
        idx_eff   = (sample_index_reg >= len) ? '0 : sample_index_reg;
        idx_inc   = idx_eff + 1'b1;
        delay_sel = (mode_eff == cwg_pkg::MODE_TRI || mode_eff == cwg_pkg::MODE_SQUARE)
                    ? fast_delay_reg : slow_delay_reg;

        wave_mode_next    = wave_mode_reg;
        pending_mode_next = pending_mode_reg;
        sample_index_next = sample_index_reg;
        hold_count_next   = hold_count_reg;
        level_next        = level_reg;
        announce          = cwg_pkg::ANN_NONE;
        strobe            = 1'b0;

        if (item.kind == cwg_pkg::KIND_CMD)
        begin
            unique case (item.rx_byte)
                cwg_pkg::CHAR_SINE:
                begin
                    pending_mode_next = cwg_pkg::MODE_SINE;
                    announce          = cwg_pkg::ANN_SINE;
                end
                cwg_pkg::CHAR_TRI:
                begin
                    pending_mode_next = cwg_pkg::MODE_TRI;
                    announce          = cwg_pkg::ANN_TRI;
                end
                cwg_pkg::CHAR_SQUARE:
                begin
                    pending_mode_next = cwg_pkg::MODE_SQUARE;
                    announce          = cwg_pkg::ANN_SQUARE;
                end
                cwg_pkg::CHAR_SAW:
                begin
                    pending_mode_next = cwg_pkg::MODE_SAW;
                    announce          = cwg_pkg::ANN_SAW;
                end
                default: ;
            endcase
        end
        else if (hold_count_reg == '0)
        begin
            wave_mode_next    = mode_eff;
            level_next        = cwg_pkg::sample_level(mode_eff, idx_eff);
            strobe            = 1'b1;
            // zero delay behaves as one
            hold_count_next   = (delay_sel == '0) ? '0 : delay_sel - 1'b1;
            sample_index_next = (idx_inc >= len) ? '0 : idx_inc;
        end
        else
        begin
            hold_count_next = hold_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg    <= cwg_pkg::MODE_SAW;
            pending_mode_reg <= cwg_pkg::MODE_SAW;
            sample_index_reg <= '0;
            hold_count_reg   <= '0;
            level_reg        <= '0;
        end
        else if (accept)
        begin
            wave_mode_reg    <= wave_mode_next;
            pending_mode_reg <= pending_mode_next;
            sample_index_reg <= sample_index_next;
            hold_count_reg   <= hold_count_next;
            level_reg        <= level_next;
        end
    end

    assign result.dac_level     = level_next;
    assign result.sample_strobe = strobe;
    assign result.announce      = announce;

    assign stat.sample_index = sample_index_reg;
    assign stat.hold_count   = hold_count_reg;

endmodule

/* rtl/core/cwg_out_buf.sv */
// ----------------------------------------------------------------------------
// Waveform generator result buffer
// Output register plus skid stage; decouples result ready from input ready.
// ----------------------------------------------------------------------------
module cwg_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cwg_pkg::result_t    push_data,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output cwg_pkg::result_t    out_data,
    output cwg_pkg::buf_stat_t  stat
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    cwg_pkg::result_t out_data_reg;
    cwg_pkg::result_t out_data_next;
    cwg_pkg::result_t skid_data_reg;
    cwg_pkg::result_t skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready      = !skid_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign stat.out_valid  = out_valid_reg;
    assign stat.skid_valid = skid_valid_reg;

endmodule

/* rtl/core/command_selected_waveform_generator.sv */
// ----------------------------------------------------------------------------
// Command-selected waveform generator
// Tick and command beats drive an 8-bit DAC level: sine, triangle, square
// or sawtooth, with per-sample hold counts from two delay registers.
//
//   channel  dir  signals                                  role
//   cmd      in   valid ready kind rx_byte                 tick or command byte
//   dac      out  valid ready dac_level sample_strobe ann. one result per beat
//   cfg      in   cfg_we cfg_index cfg_data                delay register write
//
// One beat per cycle while cmd.ready is high; each result is registered.
// The state core registers hold counter and index on each accepted beat.
// A two-entry result buffer keeps cmd.ready high while the dac side stalls
// with one entry free; cmd.ready drops only once both entries hold results.
// Reset: delays 5150/2550, sawtooth, index and hold count 0, buffer empty.
// ----------------------------------------------------------------------------
`include "command_selected_waveform_generator_defines.svh"

module command_selected_waveform_generator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cwg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwg_pkg::DELAY_W-1:0]    cfg_data,
    cwg_in_if.sink                         cmd,
    cwg_out_if.source                      dac
);

    cwg_pkg::item_t      item;
    cwg_pkg::result_t    core_result;
    cwg_pkg::result_t    out_data;
    cwg_pkg::core_stat_t core_stat;
    cwg_pkg::buf_stat_t  buf_stat;
    logic                accept;
    logic                buf_ready;

    assign item.kind    = cmd.kind;
    assign item.rx_byte = cmd.rx_byte;
    assign accept       = cmd.valid && buf_ready;
    assign cmd.ready    = buf_ready;

    cwg_wave_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .result    (core_result),
        .stat      (core_stat)
    );

    cwg_out_buf u_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (core_result),
        .push_ready (buf_ready),
        .out_valid  (dac.valid),
        .out_ready  (dac.ready),
        .out_data   (out_data),
        .stat       (buf_stat)
    );

    assign dac.dac_level     = out_data.dac_level;
    assign dac.sample_strobe = out_data.sample_strobe;
    assign dac.announce      = out_data.announce;

    `CWG_ASSERT_SAME(a_strobe_on_tick, clk, rst_n, core_result.sample_strobe, item.kind == cwg_pkg::KIND_TICK)
    `CWG_ASSERT_SAME(a_ann_no_strobe, clk, rst_n, core_result.announce != cwg_pkg::ANN_NONE, !core_result.sample_strobe)
    `CWG_ASSERT_SAME(a_skid_behind_out, clk, rst_n, buf_stat.skid_valid, buf_stat.out_valid)
    `CWG_ASSERT_NEXT(a_hold_countdown, clk, rst_n, accept && item.kind == cwg_pkg::KIND_TICK && core_stat.hold_count != '0, core_stat.hold_count == $past(core_stat.hold_count) - 1'b1)

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Waveform generator testbench
// Drives tick and command beats into the generator and checks every DAC
// result against a cycle-free model of the hold counter, sample position and
// mode switch. Delay registers are changed between phases while idle; both
// sides of the stream idle at random and the sink holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        cwg_pkg::item_t beat;
        logic [3:0]     gap;
    } queued_beat_t;

    localparam logic [3:0][7:0] COMMAND_CHARS = {cwg_pkg::CHAR_SAW, cwg_pkg::CHAR_SQUARE,
                                                 cwg_pkg::CHAR_TRI, cwg_pkg::CHAR_SINE};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [cwg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cwg_pkg::DELAY_W-1:0]   cfg_data;

    cwg_in_if  cmd_bus ();
    cwg_out_if dac_bus ();

    command_selected_waveform_generator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .dac       (dac_bus)
    );

    always #6 clk = ~clk;

    queued_beat_t     beats_to_send [$];
    cwg_pkg::result_t expected_dac [$];
    int unsigned      mismatches = 0;
    int unsigned      idle_left = 0;
    int unsigned      stall_left = 0;
    int unsigned      hold_off = 0;
    logic             calm;
    logic             squeeze;
    logic             squeezed = 1'b0;

    // generator shadow
    logic [1:0]                  play_mode;
    logic [1:0]                  next_mode;
    logic [cwg_pkg::INDEX_W-1:0] wave_pos;
    logic [cwg_pkg::DELAY_W-1:0] hold_left;
    logic [cwg_pkg::LEVEL_W-1:0] dac_now;
    logic [cwg_pkg::DELAY_W-1:0] slow_ticks;
    logic [cwg_pkg::DELAY_W-1:0] fast_ticks;

    function automatic cwg_pkg::result_t next_dac_result(input cwg_pkg::item_t beat);
        cwg_pkg::result_t            r;
        int                          span;
        logic                        fast;
        logic [cwg_pkg::DELAY_W-1:0] ticks;
        r.announce      = cwg_pkg::ANN_NONE;
        r.sample_strobe = 1'b0;
        if (beat.kind == cwg_pkg::KIND_CMD)
        begin
            case (beat.rx_byte)
                cwg_pkg::CHAR_SINE:
                begin
                    next_mode  = cwg_pkg::MODE_SINE;
                    r.announce = cwg_pkg::ANN_SINE;
                end
                cwg_pkg::CHAR_TRI:
                begin
                    next_mode  = cwg_pkg::MODE_TRI;
                    r.announce = cwg_pkg::ANN_TRI;
                end
                cwg_pkg::CHAR_SQUARE:
                begin
                    next_mode  = cwg_pkg::MODE_SQUARE;
                    r.announce = cwg_pkg::ANN_SQUARE;
                end
                cwg_pkg::CHAR_SAW:
                begin
                    next_mode  = cwg_pkg::MODE_SAW;
                    r.announce = cwg_pkg::ANN_SAW;
                end
                default:
                begin
                end
            endcase
        end
        else if (hold_left == '0)
        begin
            if (wave_pos == '0)
                play_mode = next_mode;
            fast = (play_mode == cwg_pkg::MODE_TRI || play_mode == cwg_pkg::MODE_SQUARE);
            span = fast ? 2 * cwg_pkg::TABLE_DEPTH - 1 : cwg_pkg::TABLE_DEPTH;
            if (int'(wave_pos) >= span)
                wave_pos = '0;
            case (play_mode)
                cwg_pkg::MODE_SINE:
                    dac_now = cwg_pkg::SINE_ROM[wave_pos[7:0]];
                cwg_pkg::MODE_TRI:
                    dac_now = (int'(wave_pos) < cwg_pkg::TABLE_DEPTH) ? wave_pos[7:0]
                            : 8'(2 * cwg_pkg::TABLE_DEPTH - 1 - int'(wave_pos));
                cwg_pkg::MODE_SQUARE:
                    dac_now = (int'(wave_pos) < cwg_pkg::TABLE_DEPTH) ? cwg_pkg::LEVEL_HIGH
                            : cwg_pkg::LEVEL_LOW;
                default:
                    dac_now = wave_pos[7:0];
            endcase
            r.sample_strobe = 1'b1;
            ticks = fast ? fast_ticks : slow_ticks;
            if (ticks == '0)
                ticks = 16'd1;
            hold_left = ticks - 16'd1;
            wave_pos  = wave_pos + 1'b1;
            if (int'(wave_pos) >= span)
                wave_pos = '0;
        end
        else
        begin
            hold_left = hold_left - 16'd1;
        end
        r.dac_level = dac_now;
        return r;
    endfunction

    // beat source
    always @(posedge clk or negedge rst_n)
    begin : beat_source
        cwg_pkg::item_t taken;
        queued_beat_t   nxt;
        if (!rst_n)
        begin
            cmd_bus.valid   <= 1'b0;
            cmd_bus.kind    <= cwg_pkg::KIND_TICK;
            cmd_bus.rx_byte <= '0;
            idle_left = 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                taken.kind    = cmd_bus.kind;
                taken.rx_byte = cmd_bus.rx_byte;
                expected_dac.push_back(next_dac_result(taken));
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (idle_left != 0)
                begin
                    idle_left = idle_left - 1;
                    cmd_bus.valid <= 1'b0;
                end
                else if (beats_to_send.size() != 0)
                begin
                    nxt = beats_to_send.pop_front();
                    cmd_bus.valid   <= 1'b1;
                    cmd_bus.kind    <= nxt.beat.kind;
                    cmd_bus.rx_byte <= nxt.beat.rx_byte;
                    idle_left = nxt.gap;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge clk or negedge rst_n)
    begin : dac_sink
        cwg_pkg::result_t want;
        if (!rst_n)
        begin
            dac_bus.ready <= 1'b0;
            stall_left = 0;
            hold_off   = 0;
        end
        else
        begin
            if (dac_bus.valid && dac_bus.ready)
            begin
                if (expected_dac.size() == 0)
                begin
                    $error("unexpected dac beat: level %0d strobe %0d announce %0d",
                           dac_bus.dac_level, dac_bus.sample_strobe, dac_bus.announce);
                    mismatches++;
                end
                else
                begin
                    want = expected_dac.pop_front();
                    if (dac_bus.dac_level !== want.dac_level)
                    begin
                        $error("dac_level: expected %0d, got %0d",
                               want.dac_level, dac_bus.dac_level);
                        mismatches++;
                    end
                    if (dac_bus.sample_strobe !== want.sample_strobe)
                    begin
                        $error("sample_strobe: expected %0d, got %0d",
                               want.sample_strobe, dac_bus.sample_strobe);
                        mismatches++;
                    end
                    if (dac_bus.announce !== want.announce)
                    begin
                        $error("announce: expected %0d, got %0d",
                               want.announce, dac_bus.announce);
                        mismatches++;
                    end
                end
                stall_left = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            else if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
            end
            if (squeeze && !squeezed)
            begin
                hold_off = 60;
                squeezed = 1'b1;
            end
            else if (hold_off != 0)
            begin
                hold_off = hold_off - 1;
            end
            dac_bus.ready <= (stall_left == 0 && hold_off == 0);
        end
    end

    task automatic queue_beat(input logic beat_kind, input logic [7:0] code,
                              input int unsigned gap);
        queued_beat_t entry;
        entry.beat.kind    = beat_kind;
        entry.beat.rx_byte = code;
        entry.gap          = 4'(gap);
        beats_to_send.push_back(entry);
    endtask

    task automatic queue_ticks(input int unsigned count);
        repeat (count)
            queue_beat(cwg_pkg::KIND_TICK, 8'($urandom), 0);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned pick;
        int unsigned gap;
        logic        burst;
        burst = 1'b0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            gap  = (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            if (pick < 86)
                queue_beat(cwg_pkg::KIND_TICK, 8'($urandom), gap);
            else if (pick < 95)
                queue_beat(cwg_pkg::KIND_CMD, COMMAND_CHARS[$urandom_range(0, 3)], gap);
            else
                queue_beat(cwg_pkg::KIND_CMD, 8'($urandom), gap);
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (beats_to_send.size() != 0 || cmd_bus.valid || expected_dac.size() != 0);
    endtask

    task automatic write_delay(input logic [cwg_pkg::CFG_IDX_W-1:0] idx,
                               input logic [cwg_pkg::DELAY_W-1:0] value);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == cwg_pkg::REG_SLOW_DELAY)
            slow_ticks = value;
        else
            fast_ticks = value;
    endtask

    initial
    begin : stimulus
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = cwg_pkg::REG_SLOW_DELAY;
        cfg_data        = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.kind    = cwg_pkg::KIND_TICK;
        cmd_bus.rx_byte = '0;
        dac_bus.ready   = 1'b0;
        calm            = 1'b1;
        squeeze         = 1'b0;
        play_mode       = cwg_pkg::MODE_SAW;
        next_mode       = cwg_pkg::MODE_SAW;
        wave_pos        = '0;
        hold_left       = '0;
        dac_now         = '0;
        slow_ticks      = cwg_pkg::SLOW_DELAY_RST;
        fast_ticks      = cwg_pkg::FAST_DELAY_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ignored bytes, several commands before the first sample, last one wins
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_SAW, 0);
        queue_beat(cwg_pkg::KIND_CMD, 8'h52, 0);
        queue_beat(cwg_pkg::KIND_CMD, 8'h00, 2);
        queue_beat(cwg_pkg::KIND_CMD, 8'hFF, 0);
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_TRI, 1);
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_SINE, 0);
        write_delay(cwg_pkg::REG_SLOW_DELAY, 16'd1);
        write_delay(cwg_pkg::REG_FAST_DELAY, 16'd1);
        queue_ticks(8);
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_SQUARE, 0);
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_TRI, 0);
        queue_beat(cwg_pkg::KIND_CMD, 8'h54, 0);
        // sine period ends, triangle takes over
        queue_ticks(cwg_pkg::TABLE_DEPTH + 40);
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_SAW, 0);
        // on into the falling half of the triangle
        queue_ticks(cwg_pkg::TABLE_DEPTH);
        settle();

        calm = 1'b0;
        queue_random(100);
        squeeze = 1'b1;
        write_delay(cwg_pkg::REG_SLOW_DELAY, 16'd2);
        write_delay(cwg_pkg::REG_FAST_DELAY, 16'd0);
        queue_random(50);
        write_delay(cwg_pkg::REG_SLOW_DELAY, 16'd0);
        write_delay(cwg_pkg::REG_FAST_DELAY, 16'd3);
        queue_random(50);
        write_delay(cwg_pkg::REG_SLOW_DELAY, 16'($urandom_range(1, 4)));
        write_delay(cwg_pkg::REG_FAST_DELAY, 16'($urandom_range(1, 4)));
        queue_random(50);
        write_delay(cwg_pkg::REG_SLOW_DELAY, 16'hFFFF);
        write_delay(cwg_pkg::REG_FAST_DELAY, 16'hFFFF);
        queue_beat(cwg_pkg::KIND_CMD, cwg_pkg::CHAR_SQUARE, 0);
        queue_random(20);

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
